@@ src/cma_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex moving average package
// Shared widths, limits and the divider request/response types.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W     = $clog2(MAX_WINDOW);
    localparam int SUM_W     = SAMPLE_BITS + PTR_W;
    localparam int RING_W    = 2 * SAMPLE_BITS;
    localparam int DIV_STEPS = (SUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [WIN_W-1:0] WINDOW_MIN   = WIN_W'(2);
    localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ src/cma_in_if.sv @@
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one complex Q1.15 sample per transaction.
// ----------------------------------------------------------------------------
interface cma_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cma_pkg::SAMPLE_BITS-1:0] sample_re;
    logic signed [cma_pkg::SAMPLE_BITS-1:0] sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

@@ src/cma_out_if.sv @@
// ----------------------------------------------------------------------------
// Mean output channel
// Valid/ready channel carrying the window mean and the number of samples held.
// ----------------------------------------------------------------------------
interface cma_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cma_pkg::SAMPLE_BITS-1:0] mean_re;
    logic signed [cma_pkg::SAMPLE_BITS-1:0] mean_im;
    logic        [cma_pkg::WIN_W-1:0]       samples_held;

    modport source (output valid, output mean_re, output mean_im, output samples_held,
                    input ready);
    modport sink   (input valid, input mean_re, input mean_im, input samples_held,
                    output ready);
endinterface

@@ src/cma_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cma_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cma_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cma_pkg::t_div_req i_req,
    output cma_pkg::t_div_rsp o_rsp
);

    logic [cma_pkg::DIV_W-1:0] r_quo;
    logic [cma_pkg::WIN_W-1:0] r_rem;
    logic [cma_pkg::WIN_W-1:0] r_div;
    logic [cma_pkg::CNT_W-1:0] r_cnt;
    logic                      r_done;

    logic [cma_pkg::WIN_W:0]   w_s1, w_s2;
    logic                      w_q1, w_q2;
    logic [cma_pkg::WIN_W-1:0] w_r1, w_r2;

    always_comb begin
        w_s1 = {r_rem, r_quo[cma_pkg::DIV_W-1]};
        w_q1 = w_s1 >= {1'b0, r_div};
        w_r1 = w_q1 ? cma_pkg::WIN_W'(w_s1 - {1'b0, r_div}) : w_s1[cma_pkg::WIN_W-1:0];
        w_s2 = {w_r1, r_quo[cma_pkg::DIV_W-2]};
        w_q2 = w_s2 >= {1'b0, r_div};
        w_r2 = w_q2 ? cma_pkg::WIN_W'(w_s2 - {1'b0, r_div}) : w_s2[cma_pkg::WIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= cma_pkg::CNT_W'(cma_pkg::DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == cma_pkg::CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= cma_pkg::DIV_W'(i_req.dividend);
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[cma_pkg::DIV_W-3:0], w_q1, w_q2};
            r_rem <= w_r2;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[cma_pkg::SUM_W-1:0];

endmodule

@@ src/complex_moving_average_top.sv @@
// ----------------------------------------------------------------------------
// Complex moving average
// Windowed mean of complex Q1.15 samples over a programmable window.
// ----------------------------------------------------------------------------
// Samples arrive on i_in (valid/ready); each transaction produces exactly one
// transaction on o_out with the real and imaginary means (truncated toward
// zero) and the number of samples currently held.
// i_cfg_we/i_cfg_wdata set the window length (clamped to 2..256) and restart
// the average; write only while the block is idle.
// After a sample is accepted: one sum update, then the shared serial divider
// runs twice (real, then imaginary part) at two quotient bits per cycle, then
// the mean is loaded into the output register. A new sample is taken only
// once the previous one has been through all of these steps.
// i_in.ready is high only while the sequencer waits for a sample, so the next
// sample may be taken while the previous result still sits in the output
// register. If the receiver stalls, the finished mean waits in the sequencer
// until the output register is free.
// Reset clears the window to 16 samples, the pointer, the count and both sums;
// no clearing pass over the ring is needed, as an entry is only read back once
// it has been written since the last restart.
// ----------------------------------------------------------------------------
module complex_moving_average_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cma_pkg::WIN_W-1:0] i_cfg_wdata,
    cma_in_if.sink                    i_in,
    cma_out_if.source                 o_out
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UPD  = 7'b0000010,
        S_SRE  = 7'b0000100,
        S_WRE  = 7'b0001000,
        S_SIM  = 7'b0010000,
        S_WIM  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    localparam int EXT_W = cma_pkg::SUM_W - cma_pkg::SAMPLE_BITS;
    localparam int SB    = cma_pkg::SAMPLE_BITS;

    t_state                           r_state;
    logic [cma_pkg::WIN_W-1:0]        r_win;
    logic [cma_pkg::PTR_W-1:0]        r_wp;
    logic [cma_pkg::WIN_W-1:0]        r_fill;
    logic signed [cma_pkg::SUM_W-1:0] r_sum_re, r_sum_im;
    logic [cma_pkg::PTR_W-1:0]        r_pos;
    logic signed [SB-1:0]             r_sre, r_sim;
    logic signed [SB-1:0]             r_mre, r_mim;
    logic                             r_out_valid;
    logic signed [SB-1:0]             r_out_re, r_out_im;
    logic [cma_pkg::WIN_W-1:0]        r_out_held;

    logic [cma_pkg::PTR_W-1:0]        w_pos;
    logic [cma_pkg::RING_W-1:0]       w_rdata;
    logic                             w_full;
    logic signed [cma_pkg::SUM_W-1:0] w_old_re, w_old_im;
    logic signed [cma_pkg::SUM_W-1:0] n_sum_re, n_sum_im;
    logic [cma_pkg::WIN_W-1:0]        n_fill;
    logic [cma_pkg::WIN_W-1:0]        w_pos_inc;
    logic [cma_pkg::PTR_W-1:0]        n_wp;
    logic [cma_pkg::WIN_W-1:0]        n_win;
    logic signed [cma_pkg::SUM_W-1:0] w_div_sum;
    logic signed [SB-1:0]             w_mean;
    logic                             w_in_acc;
    logic                             w_out_free;
    cma_pkg::t_div_req                w_req;
    cma_pkg::t_div_rsp                w_rsp;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_pos      = ({1'b0, r_wp} >= r_win) ? '0 : r_wp;

    cma_ram #(
        .WIDTH (cma_pkg::RING_W),
        .DEPTH (cma_pkg::MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_UPD),
        .i_waddr (r_pos),
        .i_wdata ({r_sre, r_sim}),
        .i_raddr (w_pos),
        .o_rdata (w_rdata)
    );

    // sum update: drop the oldest sample once the window is full
    always_comb begin
        w_full   = r_fill >= r_win;
        w_old_re = {{EXT_W{w_rdata[cma_pkg::RING_W-1]}}, w_rdata[cma_pkg::RING_W-1 -: SB]};
        w_old_im = {{EXT_W{w_rdata[SB-1]}}, w_rdata[SB-1:0]};
        n_sum_re = r_sum_re + {{EXT_W{r_sre[SB-1]}}, r_sre} - (w_full ? w_old_re : '0);
        n_sum_im = r_sum_im + {{EXT_W{r_sim[SB-1]}}, r_sim} - (w_full ? w_old_im : '0);
        n_fill   = w_full ? r_win : r_fill + 1'b1;
        w_pos_inc = {1'b0, r_pos} + 1'b1;
        n_wp     = (w_pos_inc >= r_win) ? '0 : w_pos_inc[cma_pkg::PTR_W-1:0];
    end

    always_comb begin
        if (i_cfg_wdata < cma_pkg::WINDOW_MIN) begin
            n_win = cma_pkg::WINDOW_MIN;
        end else if (i_cfg_wdata > cma_pkg::WINDOW_MAX) begin
            n_win = cma_pkg::WINDOW_MAX;
        end else begin
            n_win = i_cfg_wdata;
        end
    end

    // shared divider works on magnitudes; sign restored on the quotient
    always_comb begin
        w_div_sum      = (r_state == S_SIM || r_state == S_WIM) ? r_sum_im : r_sum_re;
        w_req.start    = (r_state == S_SRE) || (r_state == S_SIM);
        w_req.dividend = w_div_sum[cma_pkg::SUM_W-1] ? cma_pkg::SUM_W'(-w_div_sum)
                                                     : cma_pkg::SUM_W'(w_div_sum);
        w_req.divisor  = r_fill;
        w_mean         = w_div_sum[cma_pkg::SUM_W-1] ? -w_rsp.quotient[SB-1:0]
                                                     : w_rsp.quotient[SB-1:0];
    end

    cma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= cma_pkg::WINDOW_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum_re    <= '0;
            r_sum_im    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // window writes are taken only between transactions
            if (i_cfg_we && r_state == S_IDLE) begin
                r_win    <= n_win;
                r_wp     <= '0;
                r_fill   <= '0;
                r_sum_re <= '0;
                r_sum_im <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_sum_re <= n_sum_re;
                    r_sum_im <= n_sum_im;
                    r_fill   <= n_fill;
                    r_wp     <= n_wp;
                    r_state  <= S_SRE;
                end
                S_SRE: r_state <= S_WRE;
                S_WRE: begin
                    if (w_rsp.done) begin
                        r_state <= S_SIM;
                    end
                end
                S_SIM: r_state <= S_WIM;
                S_WIM: begin
                    if (w_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sre <= i_in.sample_re;
            r_sim <= i_in.sample_im;
            r_pos <= w_pos;
        end
        if (r_state == S_WRE && w_rsp.done) begin
            r_mre <= w_mean;
        end
        if (r_state == S_WIM && w_rsp.done) begin
            r_mim <= w_mean;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_re   <= r_mre;
            r_out_im   <= r_mim;
            r_out_held <= r_fill;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.mean_re      = r_out_re;
    assign o_out.mean_im      = r_out_im;
    assign o_out.samples_held = r_out_held;

    // fill count never exceeds the window
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_win)
        else $error("fill count above window length");

    // write pointer stays inside the window once a sample has gone through
    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRE) |-> ({1'b0, r_wp} < r_win))
        else $error("write pointer outside window");

    // divider only completes while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WRE || r_state == S_WIM))
        else $error("divider result with no waiting sequencer");

    // an accepted sample with no window write alongside moves the sequencer into the update step
    a_acc_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_cfg_we) |=> (r_state == S_UPD))
        else $error("accepted transaction not processed");

    // a delivered mean always covers at least one sample
    a_held_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_held != '0))
        else $error("result with no samples held");

endmodule
